// ----- rtl/core/lfu_pkg.sv -----
// Shared types and codes for the LFU cache block.
`default_nettype none
package lfu_pkg;
  localparam int unsigned ReqTypeW = 2;
  localparam int unsigned KeyFieldW = 40;
  localparam int unsigned CountFieldW = 16;
  localparam int unsigned CapW = 5;
  localparam logic [CapW-1:0] CapReset = 5'd10;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_ACCESS = 2'd1,
    REQ_DUMP   = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  // One classified request, front to back.
  typedef struct packed {
    req_e                   kind;
    logic [KeyFieldW-1:0]   key;
    logic [CountFieldW-1:0] count;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    req_e                   kind;
    logic                   hit;
    logic                   evicted;
    logic [KeyFieldW-1:0]   evicted_key;
    logic                   full_reject;
    logic                   entry_valid;
    logic [KeyFieldW-1:0]   entry_key;
    logic [CountFieldW-1:0] entry_count;
    logic                   last;
  } resp_t;
endpackage
`default_nettype wire

// ----- rtl/core/lfu_front.sv -----
// Request front end: key masking, count saturation, drop of unused codes, two-entry queue.
`default_nettype none
module lfu_front #(
  parameter int unsigned KEY_CHARS  = 5,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [lfu_pkg::ReqTypeW-1:0]        req_type_i,
  input  wire logic [lfu_pkg::KeyFieldW-1:0]       key_i,
  input  wire logic [lfu_pkg::CountFieldW-1:0]     load_count_i,
  output logic                                     cmd_valid_o,
  input  wire logic                                cmd_ready_i,
  output lfu_pkg::cmd_t                            cmd_o
);
  localparam int unsigned KeyW = KEY_CHARS * 8;
  localparam logic [lfu_pkg::KeyFieldW-1:0] KeyMask =
      lfu_pkg::KeyFieldW'((65'd1 << KeyW) - 65'd1);
  localparam logic [lfu_pkg::CountFieldW-1:0] CountMax =
      (COUNT_BITS >= lfu_pkg::CountFieldW) ? {lfu_pkg::CountFieldW{1'b1}}
      : lfu_pkg::CountFieldW'((33'd1 << COUNT_BITS) - 33'd1);

  lfu_pkg::cmd_t q_mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  lfu_pkg::cmd_t in_cmd;
  logic          push, pop;

  always_comb begin
    in_cmd.kind  = lfu_pkg::req_e'(req_type_i);
    in_cmd.key   = key_i & KeyMask;
    in_cmd.count = (load_count_i > CountMax) ? CountMax : load_count_i;
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o && (in_cmd.kind != lfu_pkg::REQ_NONE);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wr_ptr_q] <= in_cmd;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (cnt_q == 2'd2) |-> !in_ready_o)
    else $error("ready while full");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      cmd_valid_o |-> (cmd_o.kind != lfu_pkg::REQ_NONE))
    else $error("unused code queued");
endmodule
`default_nettype wire

// ----- rtl/core/lfu_back.sv -----
// Cache engine: entry storage, sequential scans for lookup, victim and dump order.
`default_nettype none
module lfu_back #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [lfu_pkg::CapW-1:0]       cap_i,
  input  wire logic                           cmd_valid_i,
  output logic                                cmd_ready_o,
  input  wire lfu_pkg::cmd_t                  cmd_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output lfu_pkg::resp_t                      resp_o
);
  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OccW = $clog2(ENTRIES + 1);
  localparam int unsigned CW   = lfu_pkg::CountFieldW;
  localparam int unsigned KW   = lfu_pkg::KeyFieldW;
  localparam logic [CW-1:0] CountMax =
      (COUNT_BITS >= CW) ? {CW{1'b1}} : CW'((33'd1 << COUNT_BITS) - 33'd1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_APPLY, ST_DUMP_SCAN, ST_DUMP_EMIT, ST_OUT
  } state_e;

  state_e              state_q;
  logic [ENTRIES-1:0]  valid_q, taken_q;
  logic [KW-1:0]       keys_q [ENTRIES];
  logic [CW-1:0]       counts_q [ENTRIES];
  lfu_pkg::cmd_t       cmd_q;
  logic [IdxW-1:0]     idx_q, match_q, free_q, min_q;
  logic                match_ok_q, free_ok_q, min_ok_q;
  logic [OccW-1:0]     occ_q, emitted_q;
  lfu_pkg::resp_t      resp_q;
  logic                out_valid_q;
  logic                dump_done_q;

  logic [OccW-1:0] cap_eff;
  logic            full;
  logic            cand_ok, cand_less;
  logic [KW-1:0]   cur_key;
  logic [CW-1:0]   cur_cnt;
  logic            out_free;

  always_comb begin
    if (cap_i == '0) cap_eff = OccW'(1);
    else if ({2'b0, cap_i} > 7'(ENTRIES)) cap_eff = OccW'(ENTRIES);
    else cap_eff = OccW'(cap_i);
  end
  assign full    = occ_q >= cap_eff;
  assign cur_key = keys_q[idx_q];
  assign cur_cnt = counts_q[idx_q];
  assign cand_ok = valid_q[idx_q] && !taken_q[idx_q];
  assign cand_less = !min_ok_q || (cur_cnt < counts_q[min_q]) ||
                     ((cur_cnt == counts_q[min_q]) && (cur_key < keys_q[min_q]));
  assign out_free    = !out_valid_q || out_ready_i;
  assign cmd_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign resp_o      = resp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      taken_q     <= '0;
      out_valid_q <= 1'b0;
      occ_q       <= '0;
      idx_q       <= '0;
      emitted_q   <= '0;
      match_ok_q  <= 1'b0;
      free_ok_q   <= 1'b0;
      min_ok_q    <= 1'b0;
      dump_done_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q      <= cmd_i;
            idx_q      <= '0;
            match_ok_q <= 1'b0;
            free_ok_q  <= 1'b0;
            min_ok_q   <= 1'b0;
            taken_q    <= '0;
            emitted_q  <= '0;
            if (cmd_i.kind == lfu_pkg::REQ_DUMP) state_q <= ST_DUMP_SCAN;
            else state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // one entry per cycle: match, first free slot, running minimum
          if (valid_q[idx_q] && cur_key == cmd_q.key && !match_ok_q) begin
            match_ok_q <= 1'b1;
            match_q    <= idx_q;
          end
          if (!valid_q[idx_q] && !free_ok_q) begin
            free_ok_q <= 1'b1;
            free_q    <= idx_q;
          end
          if (cand_ok && cand_less) begin
            min_ok_q <= 1'b1;
            min_q    <= idx_q;
          end
          if (idx_q == LastIdx) state_q <= ST_APPLY;
          else idx_q <= idx_q + 1'b1;
        end
        ST_APPLY: begin
          // held while the previous result beat still waits
          if (out_free) begin
            resp_q             <= '0;
            resp_q.kind        <= cmd_q.kind;
            resp_q.entry_key   <= cmd_q.key;
            resp_q.last        <= 1'b1;
            if (cmd_q.kind == lfu_pkg::REQ_LOAD) begin
              if (match_ok_q) begin
                counts_q[match_q]  <= cmd_q.count;
                resp_q.hit         <= 1'b1;
                resp_q.entry_count <= cmd_q.count;
              end else if (full) begin
                resp_q.full_reject <= 1'b1;
              end else begin
                if (free_ok_q) begin
                  valid_q[free_q]  <= 1'b1;
                  keys_q[free_q]   <= cmd_q.key;
                  counts_q[free_q] <= cmd_q.count;
                  occ_q            <= occ_q + 1'b1;
                end
                resp_q.entry_count <= cmd_q.count;
              end
            end else begin
              if (match_ok_q) begin
                resp_q.hit <= 1'b1;
                if (counts_q[match_q] < CountMax) begin
                  counts_q[match_q]  <= counts_q[match_q] + 1'b1;
                  resp_q.entry_count <= counts_q[match_q] + 1'b1;
                end else begin
                  resp_q.entry_count <= counts_q[match_q];
                end
              end else begin
                resp_q.entry_count <= CW'(1);
                if (full && min_ok_q) begin
                  // victim is dropped: new key goes to the lower of victim slot and first free slot
                  resp_q.evicted     <= 1'b1;
                  resp_q.evicted_key <= keys_q[min_q];
                  if (free_ok_q && free_q < min_q) begin
                    valid_q[min_q]   <= 1'b0;
                    valid_q[free_q]  <= 1'b1;
                    keys_q[free_q]   <= cmd_q.key;
                    counts_q[free_q] <= CW'(1);
                  end else begin
                    keys_q[min_q]   <= cmd_q.key;
                    counts_q[min_q] <= CW'(1);
                  end
                end else if (free_ok_q) begin
                  valid_q[free_q]  <= 1'b1;
                  keys_q[free_q]   <= cmd_q.key;
                  counts_q[free_q] <= CW'(1);
                  occ_q            <= occ_q + 1'b1;
                end
              end
            end
            state_q <= ST_OUT;
          end
        end
        ST_DUMP_SCAN: begin
          if (cand_ok && cand_less) begin
            min_ok_q <= 1'b1;
            min_q    <= idx_q;
          end
          if (idx_q == LastIdx) state_q <= ST_DUMP_EMIT;
          else idx_q <= idx_q + 1'b1;
        end
        ST_DUMP_EMIT: begin
          if (out_free) begin
            resp_q      <= '0;
            resp_q.kind <= lfu_pkg::REQ_DUMP;
            resp_q.last <= 1'b1;
            out_valid_q <= 1'b1;
            idx_q       <= '0;
            min_ok_q    <= 1'b0;
            if (min_ok_q) begin
              resp_q.entry_valid <= 1'b1;
              resp_q.entry_key   <= keys_q[min_q];
              resp_q.entry_count <= counts_q[min_q];
              resp_q.last        <= (emitted_q + 1'b1 == occ_q);
              taken_q[min_q]     <= 1'b1;
              emitted_q          <= emitted_q + 1'b1;
              state_q <= (emitted_q + 1'b1 == occ_q) ? ST_IDLE : ST_DUMP_SCAN;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      occ_q == OccW'($countones(valid_q)))
    else $error("occupancy out of step with valid bits");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == ST_OUT) |-> !resp_q.entry_valid)
    else $error("load or access flagged as dump entry");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_q && !out_ready_i) |=> $stable(resp_q))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == ST_APPLY && out_free && cmd_q.kind == lfu_pkg::REQ_ACCESS) |=>
      (occ_q != '0))
    else $error("access left cache empty");
endmodule
`default_nettype wire

// ----- rtl/core/lfu_cache_replacement.sv -----
// Top level of the LFU cache: config register, front queue and cache engine.
//
// channel  direction  handshake              payload
// cfg      in         cfg_valid_i/cfg_ready_o cfg_data_i (capacity_in_use)
// req      in         in_valid_i/in_ready_o  req_type_i, key_i, load_count_i
// resp     out        out_valid_o/out_ready_i resp_kind_o .. last_o
//
// Load/access: one entry scanned per cycle, then an apply state updates the entry
//   registers and the result register, and an output state raises the result beat.
// Dump: each output beat is a fresh minimum scan over the untaken entries; apply,
//   output and dump emit all wait while the previous result beat is stalled.
// Reset clears valid bits and control; key/count storage is undefined until written.
// The front queue holds two beats, so requests are taken while the engine works
// or waits on a stalled output beat.
`default_nettype none
module lfu_cache_replacement #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_CHARS  = 5,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [lfu_pkg::CapW-1:0]        cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [lfu_pkg::ReqTypeW-1:0]    req_type_i,
  input  wire logic [lfu_pkg::KeyFieldW-1:0]   key_i,
  input  wire logic [lfu_pkg::CountFieldW-1:0] load_count_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [lfu_pkg::ReqTypeW-1:0]         resp_kind_o,
  output logic                                 hit_o,
  output logic                                 evicted_o,
  output logic [lfu_pkg::KeyFieldW-1:0]        evicted_key_o,
  output logic                                 full_reject_o,
  output logic                                 entry_valid_o,
  output logic [lfu_pkg::KeyFieldW-1:0]        entry_key_o,
  output logic [lfu_pkg::CountFieldW-1:0]      entry_count_o,
  output logic                                 last_o
);
  logic [lfu_pkg::CapW-1:0] cap_q;
  lfu_pkg::cmd_t  cmd;
  lfu_pkg::resp_t resp;
  logic           cmd_valid, cmd_ready;

  // capacity register; always writable
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cap_q <= lfu_pkg::CapReset;
    else if (cfg_valid_i) cap_q <= cfg_data_i;
  end

  lfu_front #(.KEY_CHARS(KEY_CHARS), .COUNT_BITS(COUNT_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .req_type_i, .key_i, .load_count_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  lfu_back #(.ENTRIES(ENTRIES), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk_i, .rst_ni, .cap_i(cap_q),
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .out_valid_o, .out_ready_i, .resp_o(resp)
  );

  assign resp_kind_o   = resp.kind;
  assign hit_o         = resp.hit;
  assign evicted_o     = resp.evicted;
  assign evicted_key_o = resp.evicted_key;
  assign full_reject_o = resp.full_reject;
  assign entry_valid_o = resp.entry_valid;
  assign entry_key_o   = resp.entry_key;
  assign entry_count_o = resp.entry_count;
  assign last_o        = resp.last;
endmodule
`default_nettype wire

// ----- test/lfu_cache_replacement_tb.sv -----
// Testbench for the LFU cache: directed table, random traffic, checked beat by beat.
`timescale 1ns / 1ps
module lfu_cache_replacement_tb;
  localparam int NumEntries = 16;
  localparam int StallLimit = 20000; // cycles with no beat on any channel
  localparam int SettleCycles = 60;  // covers one request through queue and engine

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lfu_pkg::CapW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [lfu_pkg::ReqTypeW-1:0] req_type = '0;
  logic [lfu_pkg::KeyFieldW-1:0] req_key = '0;
  logic [lfu_pkg::CountFieldW-1:0] req_count = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  lfu_pkg::resp_t got;

  lfu_cache_replacement dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .req_type_i(req_type), .key_i(req_key), .load_count_i(req_count),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .resp_kind_o(got.kind), .hit_o(got.hit), .evicted_o(got.evicted),
    .evicted_key_o(got.evicted_key), .full_reject_o(got.full_reject),
    .entry_valid_o(got.entry_valid), .entry_key_o(got.entry_key),
    .entry_count_o(got.entry_count), .last_o(got.last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the cache contents and the capacity register.
  bit                              sh_valid [NumEntries];
  logic [lfu_pkg::KeyFieldW-1:0]   sh_key   [NumEntries];
  logic [lfu_pkg::CountFieldW-1:0] sh_count [NumEntries];
  logic [lfu_pkg::CapW-1:0]        sh_cap = lfu_pkg::CapReset;

  lfu_pkg::resp_t pending_beats [$];
  int errors = 0;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;    // phases without any idling
  bit sink_busy = 1'b0;  // sink never stalls in this phase

  function automatic int pick_gap();
    if (no_gaps) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(10, 60);
  endfunction

  // Lowest entry by count then key, skipping marked ones; -1 if none.
  function automatic int lowest_entry(bit skip [NumEntries]);
    int best;
    best = -1;
    for (int i = 0; i < NumEntries; i++) begin
      if (!sh_valid[i] || skip[i]) continue;
      if (best < 0 || sh_count[i] < sh_count[best] ||
          (sh_count[i] == sh_count[best] && sh_key[i] < sh_key[best])) best = i;
    end
    return best;
  endfunction

  // Work out the beats for one accepted request and update the shadow cache.
  task automatic predict_request(lfu_pkg::req_e r, logic [lfu_pkg::KeyFieldW-1:0] k,
                                 logic [lfu_pkg::CountFieldW-1:0] c);
    int idx, occ, cap, v, free_idx;
    bit skip [NumEntries];
    lfu_pkg::resp_t b;
    idx = -1; occ = 0; free_idx = -1;
    cap = (sh_cap == 0) ? 1 : ((sh_cap > NumEntries) ? NumEntries : int'(sh_cap));
    for (int i = 0; i < NumEntries; i++) begin
      skip[i] = 1'b0;
      if (sh_valid[i]) begin
        occ++;
        if (idx < 0 && sh_key[i] == k) idx = i;
      end
    end
    b = '0;
    b.kind = r;
    b.last = 1'b1;
    b.entry_key = k;
    case (r)
      lfu_pkg::REQ_LOAD: begin
        if (idx >= 0) begin
          sh_count[idx] = c;
          b.hit = 1'b1; b.entry_count = c;
        end else if (occ >= cap) begin
          b.full_reject = 1'b1;
        end else begin
          for (int i = NumEntries - 1; i >= 0; i--) if (!sh_valid[i]) free_idx = i;
          sh_valid[free_idx] = 1'b1; sh_key[free_idx] = k; sh_count[free_idx] = c;
          b.entry_count = c;
        end
        pending_beats.push_back(b);
      end
      lfu_pkg::REQ_ACCESS: begin
        if (idx >= 0) begin
          if (sh_count[idx] != '1) sh_count[idx]++;
          b.hit = 1'b1; b.entry_count = sh_count[idx];
        end else begin
          if (occ >= cap) begin
            v = lowest_entry(skip);
            b.evicted = 1'b1; b.evicted_key = sh_key[v];
            sh_valid[v] = 1'b0;
          end
          for (int i = NumEntries - 1; i >= 0; i--) if (!sh_valid[i]) free_idx = i;
          if (free_idx >= 0) begin
            sh_valid[free_idx] = 1'b1; sh_key[free_idx] = k;
            sh_count[free_idx] = lfu_pkg::CountFieldW'(1);
          end
          b.entry_count = lfu_pkg::CountFieldW'(1);
        end
        pending_beats.push_back(b);
      end
      lfu_pkg::REQ_DUMP: begin
        b.entry_key = '0;
        if (occ == 0) pending_beats.push_back(b);
        for (int n = 0; n < occ; n++) begin
          v = lowest_entry(skip);
          skip[v] = 1'b1;
          b.entry_valid = 1'b1; b.entry_key = sh_key[v]; b.entry_count = sh_count[v];
          b.last = (n == occ - 1);
          pending_beats.push_back(b);
        end
      end
      default: ; // unused type: block drops it silently
    endcase
  endtask

  // Drive one request beat; called at a clock edge. Valid stays up across
  // back-to-back beats and drops only when a gap follows. Ready is sampled at
  // the falling edge, where it holds its value for the next rising edge.
  task automatic send_request(lfu_pkg::req_e r, logic [lfu_pkg::KeyFieldW-1:0] k,
                              logic [lfu_pkg::CountFieldW-1:0] c, bit typed,
                              lfu_pkg::resp_t typed_beat);
    int g;
    bit ok;
    in_valid <= 1'b1; req_type <= r; req_key <= k; req_count <= c;
    do begin
      @(negedge clk);
      ok = in_ready;
      @(posedge clk);
    end while (!ok);
    predict_request(r, k, c);
    // directed rows with a hand-written answer override the predicted beat
    if (typed) begin
      void'(pending_beats.pop_back());
      pending_beats.push_back(typed_beat);
    end
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Let the block drain, then write the capacity register.
  task automatic write_capacity(logic [lfu_pkg::CapW-1:0] value);
    bit ok;
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    cfg_valid <= 1'b1; cfg_data <= value;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    sh_cap = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Sink side: random stalls (none while sink_busy), compare each beat against the oldest expectation.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("%0t watchdog: no beat for %0d cycles", $time, StallLimit);
      $display("Mismatches found");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      if (pending_beats.size() == 0) begin
        $display("%0t unexpected beat: %p", $time, got);
        errors++;
      end else begin
        lfu_pkg::resp_t e;
        e = pending_beats.pop_front();
        if (e !== got) begin
          $display("%0t beat mismatch: expected %p, actual %p", $time, e, got);
          errors++;
        end
      end
    end
    if (sink_busy) out_ready <= 1'b1;
    else if ($urandom_range(0, 19) == 0) out_ready <= ~out_ready;
    else if (!out_ready && $urandom_range(0, 2) == 0) out_ready <= 1'b1;
    else if (out_ready && $urandom_range(0, 5) == 0) out_ready <= 1'b0;
  end

  typedef struct {
    lfu_pkg::req_e                   r;
    logic [lfu_pkg::KeyFieldW-1:0]   k;
    logic [lfu_pkg::CountFieldW-1:0] c;
    bit                              typed;
    lfu_pkg::resp_t                  beat;
  } row_t;

  row_t plan [$];
  logic [lfu_pkg::KeyFieldW-1:0] key_pool [20];

  function automatic void add_row(lfu_pkg::req_e r, logic [lfu_pkg::KeyFieldW-1:0] k,
                                  logic [lfu_pkg::CountFieldW-1:0] c, bit typed = 0,
                                  lfu_pkg::resp_t beat = '0);
    row_t w;
    w.r = r; w.k = k; w.c = c; w.typed = typed; w.beat = beat;
    plan.push_back(w);
  endfunction

  function automatic lfu_pkg::resp_t mk(lfu_pkg::req_e r, bit rej, bit val,
                                        logic [lfu_pkg::KeyFieldW-1:0] k,
                                        logic [lfu_pkg::CountFieldW-1:0] c);
    lfu_pkg::resp_t b;
    b = '0;
    b.kind = r; b.full_reject = rej; b.entry_valid = val;
    b.entry_key = k; b.entry_count = c; b.last = 1'b1;
    return b;
  endfunction

  task automatic random_phase(int n);
    logic [lfu_pkg::KeyFieldW-1:0] k;
    logic [lfu_pkg::CountFieldW-1:0] c;
    int sel;
    lfu_pkg::req_e r;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      r = (sel < 50) ? lfu_pkg::REQ_ACCESS : (sel < 85) ? lfu_pkg::REQ_LOAD :
          (sel < 95) ? lfu_pkg::REQ_DUMP : lfu_pkg::REQ_NONE;
      k = ($urandom_range(0, 9) == 0) ? lfu_pkg::KeyFieldW'({$urandom, $urandom})
          : key_pool[$urandom_range(0, 19)];
      case ($urandom_range(0, 5))
        0: c = '1;
        1: c = lfu_pkg::CountFieldW'($urandom);
        default: c = lfu_pkg::CountFieldW'($urandom_range(0, 8));
      endcase
      send_request(r, k, c, 1'b0, '0);
    end
  endtask

  initial begin
    logic [lfu_pkg::CapW-1:0] caps [6];
    caps[0] = 5'd16; caps[1] = 5'd0; caps[2] = 5'd31; caps[3] = 5'd3; caps[4] = 5'd1;
    caps[5] = lfu_pkg::CapW'($urandom_range(2, 15));
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 20; i++) key_pool[i] = lfu_pkg::KeyFieldW'({$urandom, $urandom});

    // Directed part, capacity at its reset value of 10.
    add_row(lfu_pkg::REQ_DUMP, '0, '0, 1, mk(lfu_pkg::REQ_DUMP, 0, 0, '0, '0)); // empty
    add_row(lfu_pkg::REQ_LOAD, '1, '1, 1, mk(lfu_pkg::REQ_LOAD, 0, 0, '1, '1)); // extremes
    add_row(lfu_pkg::REQ_ACCESS, '1, '0);                                  // saturates
    add_row(lfu_pkg::REQ_LOAD, '0, '0, 1, mk(lfu_pkg::REQ_LOAD, 0, 0, '0, '0));
    add_row(lfu_pkg::REQ_ACCESS, '0, 16'h1234);
    add_row(lfu_pkg::REQ_LOAD, '0, 16'h00FF);                     // update present key
    add_row(lfu_pkg::REQ_NONE, 40'h4142434445, 16'h5555);         // ignored type
    for (int i = 2; i < 10; i++) add_row(lfu_pkg::REQ_ACCESS, key_pool[i], '0); // to 10
    add_row(lfu_pkg::REQ_LOAD, 40'h7A7A7A7A7A, 16'd3, 1,
            mk(lfu_pkg::REQ_LOAD, 1, 0, 40'h7A7A7A7A7A, '0));
    add_row(lfu_pkg::REQ_ACCESS, 40'h6162630000, '0);             // evict, tie on count
    add_row(lfu_pkg::REQ_ACCESS, 40'h6162630000, '0);
    add_row(lfu_pkg::REQ_DUMP, '0, '0);
    add_row(lfu_pkg::REQ_NONE, '1, '1);
    add_row(lfu_pkg::REQ_DUMP, 40'h0101010101, 16'hAAAA);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    foreach (plan[i]) send_request(plan[i].r, plan[i].k, plan[i].c, plan[i].typed, plan[i].beat);

    // Random part: one phase per capacity setting, lowering below occupancy included.
    foreach (caps[p]) begin
      write_capacity(caps[p]);
      no_gaps = (p % 3 == 1);
      sink_busy = (p % 3 == 2);
      random_phase(48);
    end
    in_valid <= 1'b0;

    while (pending_beats.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (pending_beats.size() != 0) begin
      $display("%0t %0d expected beats never arrived", $time, pending_beats.size());
      errors++;
    end
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/core/lfu_pkg.sv
rtl/core/lfu_front.sv
rtl/core/lfu_back.sv
rtl/core/lfu_cache_replacement.sv
test/lfu_cache_replacement_tb.sv
